// ===== hdl/assert_macros.svh =====
// Assertion macros used by the ring buffer RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hdl/brb_pkg.sv =====
// Package for the byte ring buffer: operation and status codes, field widths.
// No dependencies.
package brb_pkg;

	localparam int DATA_W = 8;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int FS_W   = 6;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_FIND  = 2'd2,
		OP_DRAIN = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_NOTERM = 2'd2
	} status_t;

endpackage

// ===== hdl/byte_ring_buffer_with_line_drain.sv =====
// Byte ring buffer with find and line drain, one two-port store under a sequencer.
// Put writes the store on accept unless full; Get reads the store, then loads the result.
// Find scans stored bytes from the read index (1 read/cycle) to a match or the end.
// Drain: find scan, then per drained word a memory read, then an output load.
// Reset (arst_n low) clears indices and count, then a clearing pass zeroes all DEPTH
// store entries; item_ready stays low during that pass. Depends on brb_pkg, brb_ram.
`include "assert_macros.svh"
module byte_ring_buffer_with_line_drain #(
	parameter int DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [brb_pkg::OP_W-1:0]    operation,
	input  logic [brb_pkg::DATA_W-1:0]  data_in,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [brb_pkg::DATA_W-1:0]  data_out,
	output logic [brb_pkg::ST_W-1:0]    status,
	output logic [brb_pkg::FS_W-1:0]    free_space,
	output logic [brb_pkg::FS_W-1:0]    position,
	output logic                        last
);

	localparam int IW = $clog2(DEPTH);
	localparam int XW = (IW > brb_pkg::FS_W) ? IW : brb_pkg::FS_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_GET,
		S_SCAN,
		S_DRN_RD,
		S_DRN_OUT
	} state_t;

	state_t state_q;

	logic [IW-1:0] wr_idx_q, rd_idx_q, cnt_q, clr_q;
	logic [IW-1:0] scan_ptr_q, issued_q, checked_q, drn_left_q;
	logic          pend_q, drain_q;
	logic [brb_pkg::DATA_W-1:0] target_q;

	logic                       out_valid_q, last_q;
	logic [brb_pkg::DATA_W-1:0] data_q;
	brb_pkg::status_t           status_q;
	logic [brb_pkg::FS_W-1:0]   free_q, pos_q;

	logic                       mem_we, mem_re;
	logic [IW-1:0]              mem_waddr, mem_raddr;
	logic [brb_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

	logic             slot_free, accept, full, hit, scan_issue, found, scan_done, short_line;
	brb_pkg::op_t     op;
	logic [IW-1:0]    found_pos;

	logic                       ld, ld_last;
	logic [brb_pkg::DATA_W-1:0] ld_data;
	brb_pkg::status_t           ld_status;
	logic [IW-1:0]              ld_cnt, ld_pos;

	function automatic logic [IW-1:0] adv(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [brb_pkg::FS_W-1:0] ext6(input logic [IW-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		return x[brb_pkg::FS_W-1:0];
	endfunction

	function automatic logic [brb_pkg::FS_W-1:0] free_of(input logic [IW-1:0] c);
		logic [XW-1:0] f;
		f = XW'(DEPTH - 1) - XW'(c);
		return f[brb_pkg::FS_W-1:0];
	endfunction

	function automatic logic [IW-1:0] used_span(input logic [IW-1:0] w, input logic [IW-1:0] r);
		return (w >= r) ? w - r : w - r + IW'(DEPTH);
	endfunction

	brb_ram #(
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		slot_free  = !out_valid_q || result_ready;
		item_ready = (state_q == S_IDLE) && slot_free;
		accept     = item_valid && item_ready;
		op         = brb_pkg::op_t'(operation);
		full       = (cnt_q == IW'(DEPTH - 1));
		hit        = (mem_rdata == target_q);
		found      = pend_q && hit;
		scan_issue = (issued_q != cnt_q) && !found;
		scan_done  = found || (!pend_q && (issued_q == cnt_q));
		found_pos  = found ? checked_q + 1'b1 : '0;
		short_line = !found || (checked_q == '0);

		mem_we    = 1'b0;
		mem_waddr = wr_idx_q;
		mem_wdata = data_in;
		mem_re    = 1'b0;
		mem_raddr = rd_idx_q;

		ld        = 1'b0;
		ld_data   = '0;
		ld_status = brb_pkg::ST_OK;
		ld_cnt    = cnt_q;
		ld_pos    = '0;
		ld_last   = 1'b1;

		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				if (accept && op == brb_pkg::OP_PUT) begin
					ld = 1'b1;
					if (full) begin
						ld_status = brb_pkg::ST_REJECT;
					end else begin
						mem_we = 1'b1;
						ld_cnt = cnt_q + 1'b1;
					end
				end
				if (accept && op == brb_pkg::OP_GET) begin
					mem_re = 1'b1;
				end
			end
			S_GET: begin
				ld      = 1'b1;
				ld_data = mem_rdata;
				if (cnt_q != '0) begin
					ld_cnt = cnt_q - 1'b1;
				end else begin
					ld_status = brb_pkg::ST_REJECT;
				end
			end
			S_SCAN: begin
				mem_re    = scan_issue;
				mem_raddr = scan_ptr_q;
				if (scan_done && !drain_q) begin
					ld     = 1'b1;
					ld_pos = found_pos;
				end else if (scan_done && short_line) begin
					ld        = 1'b1;
					ld_status = brb_pkg::ST_NOTERM;
				end
			end
			S_DRN_RD: begin
				mem_re = 1'b1;
			end
			S_DRN_OUT: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_data = mem_rdata;
					ld_cnt  = cnt_q - 1'b1;
					ld_last = (drn_left_q == IW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				out_valid_q <= 1'b1;
				data_q      <= ld_data;
				status_q    <= ld_status;
				free_q      <= free_of(ld_cnt);
				pos_q       <= ext6(ld_pos);
				last_q      <= ld_last;
				cnt_q       <= ld_cnt;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= adv(clr_q);
					if (clr_q == IW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (op)
							brb_pkg::OP_PUT: begin
								if (!full) begin
									wr_idx_q <= adv(wr_idx_q);
								end
							end
							brb_pkg::OP_GET: begin
								state_q <= S_GET;
							end
							default: begin
								drain_q    <= (op == brb_pkg::OP_DRAIN);
								target_q   <= (op == brb_pkg::OP_FIND) ? data_in : '0;
								scan_ptr_q <= rd_idx_q;
								issued_q   <= '0;
								checked_q  <= '0;
								pend_q     <= 1'b0;
								state_q    <= S_SCAN;
							end
						endcase
					end
				end
				S_GET: begin
					if (cnt_q != '0) begin
						rd_idx_q <= adv(rd_idx_q);
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					pend_q <= scan_issue;
					if (scan_issue) begin
						scan_ptr_q <= adv(scan_ptr_q);
						issued_q   <= issued_q + 1'b1;
					end
					if (pend_q) begin
						checked_q <= checked_q + 1'b1;
					end
					if (scan_done) begin
						if (!drain_q || short_line) begin
							state_q <= S_IDLE;
						end else begin
							drn_left_q <= found_pos;
							state_q    <= S_DRN_RD;
						end
					end
				end
				S_DRN_RD: begin
					state_q <= S_DRN_OUT;
				end
				S_DRN_OUT: begin
					if (slot_free) begin
						rd_idx_q   <= adv(rd_idx_q);
						drn_left_q <= drn_left_q - 1'b1;
						state_q    <= (drn_left_q == IW'(1)) ? S_IDLE : S_DRN_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign data_out     = data_q;
	assign status       = status_q;
	assign free_space   = free_q;
	assign position     = pos_q;
	assign last         = last_q;

	`ASSERT_ALWAYS(a_cnt_max, cnt_q <= IW'(DEPTH - 1), "stored count above capacity")
	`ASSERT_ALWAYS(a_cnt_idx, cnt_q == used_span(wr_idx_q, rd_idx_q), "count vs indices")
	`ASSERT_ALWAYS(a_clear_quiet, state_q != S_CLEAR || !(out_valid_q || item_ready), "busy in clear")
	`ASSERT_NEXT(a_put_result, accept && op == brb_pkg::OP_PUT, out_valid_q && last_q, "no put result")

endmodule

// ===== hdl/brb_ram.sv =====
// Byte store of the ring buffer: one write port, one read port, registered read data.
// Depends on brb_pkg.
module brb_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [brb_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [brb_pkg::DATA_W-1:0] rdata
);

	logic [brb_pkg::DATA_W-1:0] mem [DEPTH];
	logic [brb_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
